### rtl/core/cbpy_pkg.sv
// Package: shared constants, types and the CORDIC arctangent table.
package cbpy_pkg;

   localparam int COMPONENT_FRAC_BITS = 14;
   localparam int TURN_UNITS = 23040;
   localparam int QUARTER_UNITS = 5760;
   localparam int CORDIC_STEPS = 24;
   localparam int STEP_BITS = 5;
   localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
   localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;
   localparam logic [31:0] RESET_TRANS_Y = 32'd196608;

   typedef enum logic {
      REQ_ROTATE = 1'b0,
      REQ_MOVE   = 1'b1
   } req_kind_type;

   // Datapath command selects
   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_LOAD_PITCH,
      CMD_LOAD_YAW,
      CMD_CORDIC_STEP,
      CMD_FINISH_PITCH,
      CMD_FINISH_YAW,
      CMD_PRODUCTS,
      CMD_COMPOSE
   } dp_cmd_type;

   typedef struct packed {
      dp_cmd_type cmd;
      logic [STEP_BITS-1:0] step;
      logic move;
      logic load_move;
   } ctrl_type;

   typedef struct packed {
      logic [15:0] right_x;
      logic [15:0] right_y;
      logic [15:0] right_z;
      logic [15:0] up_x;
      logic [15:0] up_y;
      logic [15:0] up_z;
      logic [15:0] fwd_x;
      logic [15:0] fwd_y;
      logic [15:0] fwd_z;
      logic [31:0] trans_x;
      logic [31:0] trans_y;
      logic [31:0] trans_z;
   } rsp_type;

   typedef struct packed {
      logic [0:0] req_type;
      logic [15:0] pitch_angle;
      logic [15:0] yaw_angle;
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [31:0] pos_z;
   } req_type_type;

   function automatic logic signed [33:0] atan_entry(input logic [STEP_BITS-1:0] i);
      logic signed [33:0] v;
      case (i)
         5'd0:  v = 34'sd2949120;
         5'd1:  v = 34'sd1740967;
         5'd2:  v = 34'sd919879;
         5'd3:  v = 34'sd466945;
         5'd4:  v = 34'sd234379;
         5'd5:  v = 34'sd117304;
         5'd6:  v = 34'sd58666;
         5'd7:  v = 34'sd29335;
         5'd8:  v = 34'sd14668;
         5'd9:  v = 34'sd7334;
         5'd10: v = 34'sd3667;
         5'd11: v = 34'sd1833;
         5'd12: v = 34'sd917;
         5'd13: v = 34'sd458;
         5'd14: v = 34'sd229;
         5'd15: v = 34'sd115;
         5'd16: v = 34'sd57;
         5'd17: v = 34'sd29;
         5'd18: v = 34'sd14;
         5'd19: v = 34'sd7;
         5'd20: v = 34'sd4;
         5'd21: v = 34'sd2;
         5'd22: v = 34'sd1;
         5'd23: v = 34'sd1;
         default: v = 34'sd0;
      endcase
      return v;
   endfunction

   // Round half up from Q30 to component scale and saturate to 16 bits
   function automatic logic [15:0] to_component(input logic signed [35:0] v);
      logic signed [35:0] r;
      r = (v + (36'sd1 <<< (29 - COMPONENT_FRAC_BITS))) >>> (30 - COMPONENT_FRAC_BITS);
      if (r > 36'sd32767) return 16'h7fff;
      else if (r < -36'sd32768) return 16'h8000;
      else return r[15:0];
   endfunction

endpackage

### rtl/core/cbpy_if.sv
// Interface: valid/ready channel carrying one payload.
interface cbpy_if #(parameter type payload_type = logic) ();
   logic valid;
   logic ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### rtl/core/cbpy_ctrl.sv
// Controller: sequences angle reduction, CORDIC iterations and basis composition.
module cbpy_ctrl import cbpy_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_move,
   output logic req_ready,
   output logic rsp_valid,
   input  logic rsp_ready,
   output ctrl_type ctrl
);
   typedef enum logic [2:0] {
      S_IDLE, S_CORDIC_P, S_FIN_P, S_CORDIC_Y, S_FIN_Y, S_PROD, S_COMP
   } state_type;

   state_type state_ff, state_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;

   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ctrl = '0;
      ctrl.cmd = CMD_NONE;
      ctrl.step = step_ff;
      ctrl.move = req_move;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_move) begin
                  ctrl.load_move = 1'b1;
                  rsp_valid_in = 1'b1;
               end else begin
                  ctrl.cmd = CMD_LOAD_PITCH;
                  step_in = '0;
                  state_in = S_CORDIC_P;
               end
            end
         end
         S_CORDIC_P, S_CORDIC_Y: begin
            ctrl.cmd = CMD_CORDIC_STEP;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_BITS'(CORDIC_STEPS - 1))
               state_in = (state_ff == S_CORDIC_P) ? S_FIN_P : S_FIN_Y;
         end
         S_FIN_P: begin
            ctrl.cmd = CMD_FINISH_PITCH;
            state_in = S_CORDIC_Y;
            step_in = '0;
         end
         S_FIN_Y: begin
            ctrl.cmd = CMD_FINISH_YAW;
            state_in = S_PROD;
         end
         S_PROD: begin
            ctrl.cmd = CMD_PRODUCTS;
            state_in = S_COMP;
         end
         S_COMP: begin
            ctrl.cmd = CMD_COMPOSE;
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      // yaw load rides on the pitch finish step
      if (state_ff == S_FIN_P) ctrl.load_move = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_busy_no_ready: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req_ready) else $error("ready while busy");
   a_comp_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_COMP |=> rsp_valid) else $error("no response after compose");
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= STEP_BITS'(CORDIC_STEPS)) else $error("step overrun");
endmodule

### rtl/core/cbpy_dp.sv
// Datapath: shared CORDIC, quadrant mapping, products and basis/translation store.
module cbpy_dp import cbpy_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  ctrl_type ctrl,
   input  req_type_type req,
   output rsp_type rsp
);
   logic signed [33:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [1:0] q_ff, q_in;
   logic [15:0] yaw_ff;
   logic signed [33:0] sp_ff, cp_ff, sy_ff, cy_ff;
   logic signed [33:0] spsy_ff, spcy_ff, sycp_ff, cpcy_ff;
   rsp_type rsp_ff;
   logic signed [33:0] sn, cs, xc, yc;

   // Reduce an angle to a quadrant and a CORDIC target in 2^-16 degree
   function automatic logic [35:0] reduce(input logic [15:0] a);
      logic signed [16:0] r;
      logic [14:0] rr;
      logic [1:0] q;
      logic [12:0] rem;
      r = 17'($signed(a));
      if (r >= 17'sd23040) r = r - 17'sd23040;
      if (r < 0) r = r + 17'sd23040;
      if (r < 0) r = r + 17'sd23040;
      rr = r[14:0];
      if (rr >= 15'd17280) begin q = 2'd3; rem = 13'(rr - 15'd17280); end
      else if (rr >= 15'd11520) begin q = 2'd2; rem = 13'(rr - 15'd11520); end
      else if (rr >= 15'd5760) begin q = 2'd1; rem = 13'(rr - 15'd5760); end
      else begin q = 2'd0; rem = 13'(rr); end
      return {q, 34'({rem, 10'd0})};
   endfunction

   function automatic logic signed [33:0] prod(input logic signed [33:0] a,
                                               input logic signed [33:0] b);
      logic signed [67:0] p;
      p = a * b + (68'sd1 <<< 29);
      return 34'(p >>> 30);
   endfunction

   always_comb begin
      xc = (x_ff < 0) ? 34'sd0 : (x_ff > ONE_Q30) ? ONE_Q30 : x_ff;
      yc = (y_ff < 0) ? 34'sd0 : (y_ff > ONE_Q30) ? ONE_Q30 : y_ff;
      case (q_ff)
         2'd0: begin sn = yc; cs = xc; end
         2'd1: begin sn = xc; cs = -yc; end
         2'd2: begin sn = -yc; cs = -xc; end
         default: begin sn = -xc; cs = yc; end
      endcase
   end

   always_comb begin
      x_in = x_ff; y_in = y_ff; z_in = z_ff; q_in = q_ff;
      case (ctrl.cmd)
         CMD_LOAD_PITCH: begin
            x_in = CORDIC_GAIN_Q30; y_in = '0;
            {q_in, z_in} = reduce(req.pitch_angle);
         end
         CMD_FINISH_PITCH: begin
            x_in = CORDIC_GAIN_Q30; y_in = '0;
            {q_in, z_in} = reduce(yaw_ff);
         end
         CMD_CORDIC_STEP: begin
            if (!z_ff[33]) begin
               x_in = x_ff - (y_ff >>> ctrl.step);
               y_in = y_ff + (x_ff >>> ctrl.step);
               z_in = z_ff - atan_entry(ctrl.step);
            end else begin
               x_in = x_ff + (y_ff >>> ctrl.step);
               y_in = y_ff - (x_ff >>> ctrl.step);
               z_in = z_ff + atan_entry(ctrl.step);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in; q_ff <= q_in;
      if (ctrl.cmd == CMD_LOAD_PITCH) yaw_ff <= req.yaw_angle;
      if (ctrl.cmd == CMD_FINISH_PITCH) begin sp_ff <= sn; cp_ff <= cs; end
      if (ctrl.cmd == CMD_FINISH_YAW) begin sy_ff <= sn; cy_ff <= cs; end
      if (ctrl.cmd == CMD_PRODUCTS) begin
         spsy_ff <= prod(sp_ff, sy_ff);
         spcy_ff <= prod(sp_ff, cy_ff);
         sycp_ff <= prod(sy_ff, cp_ff);
         cpcy_ff <= prod(cp_ff, cy_ff);
      end
      if (reset) begin
         rsp_ff <= '0;
         rsp_ff.right_x <= to_component(-36'(ONE_Q30));
         rsp_ff.up_y <= to_component(36'(ONE_Q30));
         rsp_ff.fwd_z <= to_component(-36'(ONE_Q30));
         rsp_ff.trans_y <= RESET_TRANS_Y;
      end else if (ctrl.load_move) begin
         rsp_ff.trans_x <= req.pos_x;
         rsp_ff.trans_y <= req.pos_y;
         rsp_ff.trans_z <= req.pos_z;
      end else if (ctrl.cmd == CMD_COMPOSE) begin
         if (!cp_ff[33]) begin
            rsp_ff.right_x <= to_component(-36'(cy_ff));
            rsp_ff.right_z <= to_component(-36'(sy_ff));
            rsp_ff.up_x <= to_component(-36'(spsy_ff));
            rsp_ff.up_y <= to_component(36'(cp_ff));
            rsp_ff.up_z <= to_component(36'(spcy_ff));
         end else begin
            rsp_ff.right_x <= to_component(36'(cy_ff));
            rsp_ff.right_z <= to_component(36'(sy_ff));
            rsp_ff.up_x <= to_component(36'(spsy_ff));
            rsp_ff.up_y <= to_component(-36'(cp_ff));
            rsp_ff.up_z <= to_component(-36'(spcy_ff));
         end
         rsp_ff.right_y <= '0;
         rsp_ff.fwd_x <= to_component(36'(sycp_ff));
         rsp_ff.fwd_y <= to_component(36'(sp_ff));
         rsp_ff.fwd_z <= to_component(-36'(cpcy_ff));
      end
   end

   assign rsp = rsp_ff;
endmodule

### rtl/core/camera_basis_from_pitch_yaw.sv
// Top level: camera basis and translation keeper with valid/ready channels.
// A move request is answered in the cycle after its acceptance. A rotate request runs
// two 24-step passes of a single shared CORDIC (pitch then yaw), with reduction,
// finish, product and compose steps around them, before its response is valid.
// Every request returns the full basis and translation; one request at a time.
module camera_basis_from_pitch_yaw import cbpy_pkg::*; (
   input logic clock,
   input logic reset,
   cbpy_if.sink req,
   cbpy_if.source rsp
);
   ctrl_type ctrl;

   cbpy_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_move(req.data.req_type[0]), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .ctrl(ctrl)
   );

   cbpy_dp u_dp (
      .clock(clock), .reset(reset), .ctrl(ctrl), .req(req.data), .rsp(rsp.data)
   );
endmodule
